### src/thist_pkg.sv
// Shared types and constants of the tile histogram equalizer.
package thist_pkg;

  // Image and tile geometry.
  localparam int LEVELS    = 65536;
  localparam int TILE_SIDE = 10;
  localparam int TILE_AREA = TILE_SIDE * TILE_SIDE;

  // Field and storage widths.
  localparam int PIXEL_W = 16;
  localparam int SCALE_W = 24;
  localparam int OUT_W   = 24;
  localparam int LEVEL_W = $clog2(LEVELS);
  localparam int BIN_W   = $clog2(TILE_AREA + 1);
  localparam int PROD_W  = BIN_W + SCALE_W;

  // Register reset value and output saturation (65535.0 in 16.8).
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(167772);
  localparam logic [OUT_W-1:0]   LEVEL_SAT   = OUT_W'(16776960);

  // Highest bin index, in the pixel width plus one and in the index width.
  localparam logic [PIXEL_W:0]   LEVEL_LAST_EXT = (PIXEL_W + 1)'(LEVELS - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_LAST     = LEVEL_W'(LEVELS - 1);
  localparam logic [BIN_W-1:0]   BIN_FULL       = BIN_W'(TILE_AREA);

  // Command codes carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_FINISH     = 2'd1,
    CMD_MAP        = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  // Operation held in the memory-read stage.
  typedef enum logic [1:0] {
    OP_ACC,
    OP_MAP,
    OP_FIN,
    OP_CLR
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FINISH,
    SEQ_CLEAR
  } seq_state_t;

  // Write request into the bin memory.
  typedef struct packed {
    logic               en;
    logic [LEVEL_W-1:0] addr;
    logic [BIN_W-1:0]   data;
  } bin_wr_t;

endpackage

### src/thist_bin_ram.sv
// Bin memory with a registered read port and read-during-write forwarding.
module thist_bin_ram
  import thist_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [LEVEL_W-1:0] rd_addr,
  input  bin_wr_t            wr,
  output logic [BIN_W-1:0]   rd_data
);

  logic [BIN_W-1:0] mem [LEVELS];
  logic [BIN_W-1:0] q_r;
  logic             fwd_r;
  logic [BIN_W-1:0] fwd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_r      <= wr.en && (wr.addr == rd_addr);
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

### src/tile_histogram_equalizer.sv
// Top level of the tile histogram equalizer.
//
// Input stream: in_tuser carries the command (accumulate, finish, map, clear)
// and in_tdata the pixel level. Accumulate and map are taken one per cycle while in_tready is high.
// Each map transaction yields one output transaction with the equalized level
// in unsigned 16.8 fixed point; the other commands yield none.
// A map result passes through the memory-read stage and the output queue before it is offered.
// Finish and clear each walk all 65536 bins through the bin memory, one bin
// per cycle, so in_tready stays low after either is accepted until the walk ends.
// The single-port-per-direction bin memory sets this walk rate.
// After reset the same walk clears the bins: in_tready stays low until it
// ends. The scale register returns to its reset value at once and the
// configuration channel is always ready.
// Results pass through a two-entry output queue. When the receiver stalls the
// queue fills and in_tready drops; no result is lost.
module tile_histogram_equalizer
  import thist_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input stream.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [PIXEL_W-1:0] in_tdata,   // [15:0] pixel
  input  logic [1:0]         in_tuser,   // [1:0] command
  // Result stream.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // [23:0] level_q8
  // Scale register write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] cfg_data
);

  seq_state_t         state_r, state_nxt;
  logic [LEVEL_W-1:0] ptr_r, ptr_nxt;
  logic [SCALE_W-1:0] scale_r;
  logic [BIN_W-1:0]   run_r;

  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [LEVEL_W-1:0] s1_addr_r;

  logic [OUT_W-1:0]   fifo_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r;

  logic               accept;
  cmd_t               in_cmd;
  logic [LEVEL_W-1:0] pix_idx;
  logic               issue;
  op_t                issue_op;
  logic [LEVEL_W-1:0] rd_addr;
  logic [BIN_W-1:0]   bin_q;
  bin_wr_t            bin_wr;
  logic [BIN_W:0]     run_ext;
  logic [BIN_W-1:0]   run_sum;
  logic [PROD_W-1:0]  prod;
  logic [OUT_W-1:0]   level;
  logic               push, pop;
  logic [2:0]         pending;

  // Input decode and level clamp.
  assign in_cmd  = cmd_t'(in_tuser);
  assign pix_idx = ({1'b0, in_tdata} > LEVEL_LAST_EXT) ? LEVEL_LAST
                                                       : in_tdata[LEVEL_W-1:0];

  // Output queue status and input flow control.
  assign pop        = out_tvalid && out_tready;
  assign push       = s1_valid_r && (s1_op_r == OP_MAP);
  assign pending    = {1'b0, cnt_r} + {2'b00, push} - {2'b00, pop};
  assign in_tready  = rst_n && (state_r == SEQ_IDLE) && (pending <= 3'd1);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = fifo_r[rd_ptr_r];
  assign cfg_ready  = 1'b1;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (accept && (in_cmd == CMD_FINISH)) begin
          state_nxt = SEQ_FINISH;
        end else if (accept && (in_cmd == CMD_CLEAR)) begin
          state_nxt = SEQ_CLEAR;
        end
      end
      SEQ_FINISH, SEQ_CLEAR: begin
        if (ptr_r == LEVEL_LAST) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: which memory read is issued this cycle.
  always_comb begin
    issue    = 1'b0;
    issue_op = OP_ACC;
    rd_addr  = pix_idx;
    ptr_nxt  = '0;
    case (state_r)
      SEQ_IDLE: begin
        issue    = accept && ((in_cmd == CMD_ACCUMULATE) || (in_cmd == CMD_MAP));
        issue_op = (in_cmd == CMD_MAP) ? OP_MAP : OP_ACC;
      end
      SEQ_FINISH: begin
        issue    = 1'b1;
        issue_op = OP_FIN;
        rd_addr  = ptr_r;
        ptr_nxt  = ptr_r + 1'b1;
      end
      SEQ_CLEAR: begin
        issue    = 1'b1;
        issue_op = OP_CLR;
        rd_addr  = ptr_r;
        ptr_nxt  = ptr_r + 1'b1;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Sequencer and scale registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_CLEAR;
      ptr_r   <= '0;
      scale_r <= SCALE_RESET;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_valid && cfg_ready) begin
        scale_r <= cfg_data;
      end
    end
  end

  // Memory-read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
    s1_op_r   <= issue_op;
    s1_addr_r <= rd_addr;
  end

  thist_bin_ram u_bin_ram (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .wr      (bin_wr),
    .rd_data (bin_q)
  );

  // Running sum for the finish walk, saturating at the tile area.
  assign run_ext = {1'b0, run_r} + {1'b0, bin_q};
  assign run_sum = (run_ext > {1'b0, BIN_FULL}) ? BIN_FULL : run_ext[BIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (accept && (in_cmd == CMD_FINISH)) begin
      run_r <= '0;
    end else if (s1_valid_r && (s1_op_r == OP_FIN)) begin
      run_r <= run_sum;
    end
  end

  // Write-back of the modified bin.
  always_comb begin
    bin_wr.en   = s1_valid_r && (s1_op_r != OP_MAP);
    bin_wr.addr = s1_addr_r;
    case (s1_op_r)
      OP_ACC:  bin_wr.data = (bin_q < BIN_FULL) ? bin_q + 1'b1 : bin_q;
      OP_FIN:  bin_wr.data = run_sum;
      OP_CLR:  bin_wr.data = '0;
      default: bin_wr.data = bin_q;
    endcase
  end

  // Map: count times scale, saturated at 65535.0.
  assign prod  = PROD_W'(bin_q) * PROD_W'(scale_r);
  assign level = (prod > PROD_W'(LEVEL_SAT)) ? LEVEL_SAT : prod[OUT_W-1:0];

  // Two-entry output queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= level;
    end
  end

endmodule

### src/thist_checker.sv
// Port-level checks of the tile histogram equalizer, bound to the top level.
module thist_checker
  import thist_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [1:0]         in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset starts the clearing walk, so no input is taken right after it.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during the clearing pass");

  // A finish or clear transaction starts a bin walk that blocks input.
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    ((in_tuser == CMD_FINISH) || (in_tuser == CMD_CLEAR)) |=> !in_tready)
    else $error("input taken during a bin walk");

endmodule

bind tile_histogram_equalizer thist_checker u_thist_checker (.*);

### tb/tile_histogram_equalizer_tb.sv
// Self-checking testbench for the tile histogram equalizer: random tiles, stalls and scale changes.
`timescale 1ns / 100ps

module tile_histogram_equalizer_tb;
  import thist_pkg::*;

  localparam int RUN_LIMIT   = 4000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    cmd_t               cmd;
    logic [PIXEL_W-1:0] pix;
  } pixel_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [PIXEL_W-1:0] in_tdata = '0;
  logic [1:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SCALE_W-1:0] cfg_data = '0;

  // Stimulus waiting for the driver, and the equalized levels still owed by the block.
  pixel_cmd_t       pending_cmds[$];
  logic [OUT_W-1:0] level_expected[$];

  // Shadow copy of the bin memory and the scale register.
  bit [BIN_W-1:0]     bin_cnt [LEVELS];
  logic [SCALE_W-1:0] scale_copy = SCALE_RESET;

  int unsigned cmds_queued = 0;
  int unsigned cmds_taken  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;

  tile_histogram_equalizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] pixel
    .in_tuser  (in_tuser),   // [1:0] command
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [23:0] level_q8
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one accepted command to the shadow bins and queue the level it yields.
  task automatic tally_item(input cmd_t cmd, input logic [PIXEL_W-1:0] pix);
    int unsigned       lvl;
    int unsigned       run;
    longint unsigned   prod;
    lvl = (pix >= LEVELS) ? LEVELS - 1 : pix;
    case (cmd)
      CMD_ACCUMULATE: begin
        // A full bin stays at the tile area.
        if (bin_cnt[lvl] < TILE_AREA) bin_cnt[lvl]++;
      end
      CMD_FINISH: begin
        // Running sum in place, saturating at the tile area.
        run = 0;
        for (int i = 0; i < LEVELS; i++) begin
          run += bin_cnt[i];
          if (run > TILE_AREA) run = TILE_AREA;
          bin_cnt[i] = BIN_W'(run);
        end
      end
      CMD_MAP: begin
        prod = bin_cnt[lvl];
        prod = prod * scale_copy;
        if (prod > LEVEL_SAT) prod = LEVEL_SAT;
        level_expected.push_back(OUT_W'(prod));
      end
      default: begin
        for (int i = 0; i < LEVELS; i++) bin_cnt[i] = '0;
      end
    endcase
  endtask

  // Input driver: one transaction at a time from the pending queue, with random gaps.
  pixel_cmd_t  cur_cmd;
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        tally_item(cur_cmd.cmd, cur_cmd.pix);
        cmds_taken++;
      end
      if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_tdata  <= cur_cmd.pix;
        in_tuser  <= cur_cmd.cmd;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 10);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off every 64 results, counted down in cycles here.
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_on = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      hold_on <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (results_seen % 64 == 40) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) hold_left--;
      hold_on <= (hold_left != 0);
    end
  end

  // Result monitor and short receiver stalls.
  logic [OUT_W-1:0] level_want;
  int unsigned      recv_wait = 0;
  bit               recv_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (level_expected.size() == 0) begin
          $error("level_q8: expected nothing, got %0d", out_tdata);
          mismatches++;
        end else begin
          level_want = level_expected.pop_front();
          if (out_tdata !== level_want) begin
            $error("level_q8: expected %0d, got %0d", level_want, out_tdata);
            mismatches++;
          end
        end
        if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
      end
      if (hold_on) begin
        out_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_cmd(input cmd_t cmd, input logic [PIXEL_W-1:0] pix);
    pixel_cmd_t item;
    item.cmd = cmd;
    item.pix = pix;
    pending_cmds.push_back(item);
    cmds_queued++;
  endtask

  // Wait until every command is taken, every level has arrived and no bin walk is running.
  task automatic wait_idle();
    do @(posedge clk); while (cmds_taken != cmds_queued || level_expected.size() != 0);
    repeat (4) @(posedge clk);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    scale_copy = value;
    cfg_valid <= 1'b0;
  endtask

  // Gray level drawn from the tile's level mix.
  logic [PIXEL_W-1:0] palette [4];

  function automatic logic [PIXEL_W-1:0] draw_level(input int unsigned mix);
    case (mix)
      0:       return PIXEL_W'($urandom_range(0, 65535));
      1:       return palette[0];
      default: return palette[$urandom_range(0, 3)];
    endcase
  endfunction

  int unsigned tile_idx;
  int unsigned rand_items;
  int unsigned mix;
  int unsigned n_acc;
  int unsigned n_map;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset scale, map before finish, extremes, finish twice, clear.
    push_cmd(CMD_MAP, 16'd0);
    push_cmd(CMD_ACCUMULATE, 16'd0);
    push_cmd(CMD_ACCUMULATE, 16'hFFFF);
    push_cmd(CMD_ACCUMULATE, 16'hFFFF);
    push_cmd(CMD_ACCUMULATE, 16'hAAAA);
    push_cmd(CMD_ACCUMULATE, 16'h5555);
    push_cmd(CMD_MAP, 16'hFFFF);
    push_cmd(CMD_FINISH, 16'hFFFF);
    push_cmd(CMD_MAP, 16'd0);
    push_cmd(CMD_MAP, 16'h8000);
    push_cmd(CMD_MAP, 16'hFFFF);
    push_cmd(CMD_FINISH, 16'd0);
    push_cmd(CMD_MAP, 16'hFFFF);
    push_cmd(CMD_MAP, 16'h5555);
    push_cmd(CMD_ACCUMULATE, 16'd0);
    push_cmd(CMD_MAP, 16'd0);
    push_cmd(CMD_CLEAR, 16'h1234);
    push_cmd(CMD_MAP, 16'hFFFF);
    wait_idle();

    // Largest scale saturates the level; an empty bin still maps to zero.
    write_scale(SCALE_W'(16777215));
    push_cmd(CMD_ACCUMULATE, 16'd7);
    push_cmd(CMD_MAP, 16'd7);
    push_cmd(CMD_MAP, 16'd6);
    wait_idle();
    write_scale('0);
    push_cmd(CMD_MAP, 16'd7);
    wait_idle();
    write_scale(SCALE_W'(1));
    push_cmd(CMD_MAP, 16'd7);
    wait_idle();

    // Random tiles: clear, accumulate, finish, map, with stray maps and accumulates mixed in.
    tile_idx   = 0;
    rand_items = 0;
    while (rand_items < 625) begin
      case (tile_idx % 4)
        0:       write_scale(SCALE_W'($urandom_range(100000, 300000)));
        1:       write_scale(SCALE_W'($urandom_range(0, 16777215)));
        2:       write_scale(SCALE_W'($urandom_range(1, 4096)));
        default: write_scale(SCALE_RESET);
      endcase
      mix = tile_idx % 3;
      palette[0] = PIXEL_W'($urandom_range(0, 65535));
      palette[1] = ($urandom_range(0, 1) != 0) ? 16'd0 : PIXEL_W'($urandom_range(0, 65535));
      palette[2] = PIXEL_W'($urandom_range(0, 65535));
      palette[3] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : PIXEL_W'($urandom_range(0, 65535));

      // A single-level tile sends at least 105 commands to one bin, so the bin can be driven past full.
      n_acc = (mix == 1) ? $urandom_range(105, 150) : $urandom_range(100, 150);
      n_map = $urandom_range(40, 60);
      push_cmd(CMD_CLEAR, PIXEL_W'($urandom_range(0, 65535)));
      repeat (n_acc) begin
        if ($urandom_range(0, 99) < 12) push_cmd(CMD_MAP, draw_level(mix));
        else push_cmd(CMD_ACCUMULATE, draw_level(mix));
      end
      push_cmd(CMD_FINISH, PIXEL_W'($urandom_range(0, 65535)));
      repeat (n_map) begin
        if ($urandom_range(0, 99) < 6) push_cmd(CMD_ACCUMULATE, draw_level(mix));
        else if ($urandom_range(0, 3) == 0) push_cmd(CMD_MAP, PIXEL_W'($urandom_range(0, 65535)));
        else push_cmd(CMD_MAP, draw_level(mix));
      end
      rand_items += n_acc + n_map + 2;
      wait_idle();
      tile_idx++;
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && level_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
src/thist_pkg.sv
src/thist_bin_ram.sv
src/tile_histogram_equalizer.sv
src/thist_checker.sv
tb/tile_histogram_equalizer_tb.sv
